@@ rtl/dvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_pkg
// Shared types, constants and helper functions for the date check and
// day-difference block.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DAYNUM_W  = 24;
  localparam int unsigned DIFF_W    = 23;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [YEAR_W-1:0] CUR_YEAR_RST      = 14'd2024;
  localparam logic [YEAR_W-1:0] EARLIEST_YEAR_RST = 14'd1500;

  // Reciprocal of 100 scaled by 2^21, rounded up. Exact for every 14-bit value.
  localparam logic [14:0] DIV100_MUL   = 15'd20972;
  localparam int unsigned DIV100_SHIFT = 21;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_YEAR  = 2'd1,
    STATUS_BAD_MONTH = 2'd2,
    STATUS_BAD_DAY   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_YEAR  = 1'b0,
    CFG_EARLIEST_YEAR = 1'b1
  } cfg_reg_e;

  // Days from March 1 to the first of the month, indexed by the raw month.
  // January and February (and month zero) count as months of the prior year.
  localparam logic [8:0] MONTH_OFFSET [16] = '{
    9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
    9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
  };

  typedef struct packed {
    status_e                     status;
    logic signed [DAYNUM_W-1:0]  day_num;
  } date_res_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     less;
    logic                     equal;
    logic                     greater;
  } cmp_res_t;

  // Floor of x / 100 by multiplication with a scaled reciprocal.
  function automatic logic [7:0] div100(input logic [YEAR_W-1:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'(DIV100_MUL);
    return prod[28:DIV100_SHIFT];
  endfunction

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [7:0]        q;
    logic [YEAR_W-1:0] r;
    q = div100(y);
    r = y - (14'(q) * 14'd100);
    return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic              leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/dvd_date_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_date_unit
// Checks one Gregorian date against the configured year window and the
// calendar, and maps it to its Rata Die day number.
// ----------------------------------------------------------------------------
module dvd_date_unit
  import dvd_pkg::*;
(
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  input  logic [YEAR_W-1:0]  cur_year_i,
  input  logic [YEAR_W-1:0]  earliest_year_i,
  output date_res_t          res_o
);

  logic              early;
  logic              neg_year;
  logic [YEAR_W-1:0] ty;
  logic [11:0]       q4;
  logic [7:0]        q100;
  logic [5:0]        q400;
  logic [22:0]       yr_pos;
  logic signed [DAYNUM_W-1:0] yr_days;
  logic [YEAR_W:0]   year_lim;
  logic              year_bad;
  logic              month_bad;
  logic              day_bad;
  status_e           status;

  // Dates in January and February count in the year before.
  assign early    = (month_i < 4'd3);
  assign neg_year = early && (year_i == '0);
  assign ty       = year_i - YEAR_W'(early);

  assign q4     = ty[YEAR_W-1:2];
  assign q100   = div100(ty);
  assign q400   = q100[7:2];
  assign yr_pos = (23'(ty) * 23'd365) + 23'(q4) - 23'(q100) + 23'(q400);

  // The year before year zero is -1: all its quotients truncate to zero.
  assign yr_days = neg_year ? -24'sd365 : $signed({1'b0, yr_pos});

  assign res_o.day_num = yr_days
                       + $signed({15'b0, MONTH_OFFSET[month_i]})
                       + $signed({19'b0, day_i})
                       - 24'sd306;

  assign year_lim  = {1'b0, cur_year_i} + 15'd1;
  assign year_bad  = (year_i < earliest_year_i) || ({1'b0, year_i} > year_lim);
  assign month_bad = !(month_i inside {[4'd1:4'd12]});
  assign day_bad   = (day_i == '0) || (day_i > month_length(month_i, leap_year(year_i)));

  always_comb begin
    if (year_bad) begin
      status = STATUS_BAD_YEAR;
    end else if (month_bad) begin
      status = STATUS_BAD_MONTH;
    end else if (day_bad) begin
      status = STATUS_BAD_DAY;
    end else begin
      status = STATUS_OK;
    end
  end

  assign res_o.status = status;

endmodule

@@ rtl/dvd_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_compare
// Subtracts two day numbers, saturates the difference to the output width
// and derives the ordering flags from the exact values.
// ----------------------------------------------------------------------------
module dvd_compare
  import dvd_pkg::*;
(
  input  logic signed [DAYNUM_W-1:0] num_a_i,
  input  logic signed [DAYNUM_W-1:0] num_b_i,
  output cmp_res_t                   res_o
);

  logic signed [DAYNUM_W:0] diff_full;
  logic                     fits;
  logic signed [DIFF_W-1:0] diff_sat;

  assign diff_full = {num_a_i[DAYNUM_W-1], num_a_i} - {num_b_i[DAYNUM_W-1], num_b_i};

  // The value fits when the bits above the output sign all repeat it.
  assign fits = (diff_full[DAYNUM_W:DIFF_W-1] == '0)
             || (diff_full[DAYNUM_W:DIFF_W-1] == '1);

  always_comb begin
    if (fits) begin
      diff_sat = diff_full[DIFF_W-1:0];
    end else if (diff_full[DAYNUM_W]) begin
      diff_sat = {1'b1, {(DIFF_W-1){1'b0}}};
    end else begin
      diff_sat = {1'b0, {(DIFF_W-1){1'b1}}};
    end
  end

  assign res_o.diff    = diff_sat;
  assign res_o.less    = (num_a_i < num_b_i);
  assign res_o.equal   = (num_a_i == num_b_i);
  assign res_o.greater = (num_a_i > num_b_i);

endmodule

@@ rtl/date_validate_and_difference.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_validate_and_difference
// Validates a pair of Gregorian dates and reports the signed distance between
// them in days.
// ----------------------------------------------------------------------------
// Each request carries two dates, a and b. Each date gets a status: a year
// outside the earliest accepted year..current_year+1 is reported first, then
// a month outside 1..12, then a day outside the month (February has 29 days
// in leap years). Both dates are mapped to their Rata Die day number, whatever
// their status, and the block returns a minus b, saturated to 23 bits,
// together with the less, equal and greater flags, which always follow the
// exact day numbers. The block takes one request per clock cycle while
// in_stall_o is low and returns one result per request: a request is
// captured in the input register, and the check and day-number logic then
// fill the result register, which holds while out_stall_i is high; the
// input side stalls only once both registers are full. The current year
// and the earliest accepted year are written through the configuration
// port, which is always ready, and should only be changed while no request
// is in flight.
// ----------------------------------------------------------------------------
module date_validate_and_difference
  import dvd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [YEAR_W-1:0]     cfg_data_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [YEAR_W-1:0]     year_a_i,
  input  logic [MONTH_W-1:0]    month_a_i,
  input  logic [DAY_W-1:0]      day_a_i,
  input  logic [YEAR_W-1:0]     year_b_i,
  input  logic [MONTH_W-1:0]    month_b_i,
  input  logic [DAY_W-1:0]      day_b_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_a_o,
  output logic [1:0]            status_b_o,
  output logic signed [DIFF_W-1:0] day_difference_o,
  output logic                  is_less_o,
  output logic                  is_equal_o,
  output logic                  is_greater_o
);

  // Configuration registers.
  logic [YEAR_W-1:0] cur_year_q, earliest_year_q;

  // Input register.
  logic               in_valid_q;
  logic [YEAR_W-1:0]  year_a_q, year_b_q;
  logic [MONTH_W-1:0] month_a_q, month_b_q;
  logic [DAY_W-1:0]   day_a_q, day_b_q;

  // Result register.
  logic                    out_valid_q, out_valid_d;
  status_e                 status_a_q, status_b_q;
  cmp_res_t                cmp_q;

  logic      out_en;
  logic      in_load;
  date_res_t res_a, res_b;
  cmp_res_t  cmp_res;

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q      <= CUR_YEAR_RST;
      earliest_year_q <= EARLIEST_YEAR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CURRENT_YEAR:  cur_year_q      <= cfg_data_i;
        CFG_EARLIEST_YEAR: earliest_year_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The result register takes new data when it is empty or being drained.
  // The input register moves forward whenever the result register can take
  // its content, so a request can enter in every cycle of a free stream.
  assign out_en      = !out_valid_q || !out_stall_i;
  assign in_load     = !in_valid_q || out_en;
  assign in_stall_o  = !in_load;
  assign out_valid_d = out_en ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      year_a_q  <= year_a_i;
      month_a_q <= month_a_i;
      day_a_q   <= day_a_i;
      year_b_q  <= year_b_i;
      month_b_q <= month_b_i;
      day_b_q   <= day_b_i;
    end
  end

  // Both dates are checked and numbered side by side.
  dvd_date_unit u_date_a (
    .year_i          (year_a_q),
    .month_i         (month_a_q),
    .day_i           (day_a_q),
    .cur_year_i      (cur_year_q),
    .earliest_year_i (earliest_year_q),
    .res_o           (res_a)
  );

  dvd_date_unit u_date_b (
    .year_i          (year_b_q),
    .month_i         (month_b_q),
    .day_i           (day_b_q),
    .cur_year_i      (cur_year_q),
    .earliest_year_i (earliest_year_q),
    .res_o           (res_b)
  );

  dvd_compare u_compare (
    .num_a_i (res_a.day_num),
    .num_b_i (res_b.day_num),
    .res_o   (cmp_res)
  );

  always_ff @(posedge clk_i) begin
    if (out_en && in_valid_q) begin
      status_a_q <= res_a.status;
      status_b_q <= res_b.status;
      cmp_q      <= cmp_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_a_o       = status_a_q;
  assign status_b_o       = status_b_q;
  assign day_difference_o = cmp_q.diff;
  assign is_less_o        = cmp_q.less;
  assign is_equal_o       = cmp_q.equal;
  assign is_greater_o     = cmp_q.greater;

  // Exactly one ordering flag is set on every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({is_less_o, is_equal_o, is_greater_o}))
    else $error("ordering flags are not one-hot");

  // The difference agrees in sign with the ordering flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((is_equal_o == (day_difference_o == '0))
                 && (is_less_o == day_difference_o[DIFF_W-1])))
    else $error("difference disagrees with ordering flags");

  // The input side stalls only behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without back-pressure");

  // A request in the input register reaches the result register when it may.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_en) |=> out_valid_q)
    else $error("request lost between input and result registers");

endmodule

@@ dv/date_pair_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_pair_checker
// Watches the request, result and register channels of the date check block,
// predicts the result of every accepted request and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module date_pair_checker
  import dvd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [YEAR_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [YEAR_W-1:0]        year_a_i,
  input  logic [MONTH_W-1:0]       month_a_i,
  input  logic [DAY_W-1:0]         day_a_i,
  input  logic [YEAR_W-1:0]        year_b_i,
  input  logic [MONTH_W-1:0]       month_b_i,
  input  logic [DAY_W-1:0]         day_b_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [1:0]               status_a_i,
  input  logic [1:0]               status_b_i,
  input  logic signed [DIFF_W-1:0] day_difference_i,
  input  logic                     is_less_i,
  input  logic                     is_equal_i,
  input  logic                     is_greater_i,
  output int                       failures_o,
  output int                       outstanding_o
);

  localparam longint DIFF_HI      = (longint'(1) <<< (DIFF_W - 1)) - 1;
  localparam longint DIFF_LO      = -(longint'(1) <<< (DIFF_W - 1));
  localparam int     REPORT_LIMIT = 10;

  typedef struct {
    status_e                  status_a;
    status_e                  status_b;
    logic signed [DIFF_W-1:0] difference;
    logic                     less;
    logic                     equal;
    logic                     greater;
  } date_pair_outcome_t;

  logic [YEAR_W-1:0]  current_year_q;
  logic [YEAR_W-1:0]  earliest_year_q;
  date_pair_outcome_t pending_outcomes[$];

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic status_e grade_date(input int y, input int m, input int d);
    if (y < int'(earliest_year_q) || y > int'(current_year_q) + 1) return STATUS_BAD_YEAR;
    if (m < 1 || m > 12) return STATUS_BAD_MONTH;
    if (d < 1 || d > days_in_month(y, m)) return STATUS_BAD_DAY;
    return STATUS_OK;
  endfunction

  // The count runs from March so that the leap day falls at the end of the
  // year; January, February and month zero belong to the year before.
  function automatic longint rata_die(input int y, input int m, input int d);
    longint yy;
    longint mm;
    yy = y;
    mm = m;
    if (mm < 3) begin
      yy -= 1;
      mm += 12;
    end
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm - 457) / 5 + d - 306;
  endfunction

  function automatic date_pair_outcome_t predict_date_pair(input int ya, input int ma,
                                                           input int da, input int yb,
                                                           input int mb, input int db);
    date_pair_outcome_t o;
    longint             na;
    longint             nb;
    longint             gap;
    na = rata_die(ya, ma, da);
    nb = rata_die(yb, mb, db);
    gap = na - nb;
    if (gap > DIFF_HI) gap = DIFF_HI;
    if (gap < DIFF_LO) gap = DIFF_LO;
    o.status_a   = grade_date(ya, ma, da);
    o.status_b   = grade_date(yb, mb, db);
    o.difference = gap[DIFF_W-1:0];
    o.less       = na < nb;
    o.equal      = na == nb;
    o.greater    = na > nb;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_pair_outcome_t want;
    if (!rst_ni) begin
      current_year_q  <= CUR_YEAR_RST;
      earliest_year_q <= EARLIEST_YEAR_RST;
      pending_outcomes.delete();
      failures_o     = 0;
      outstanding_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_CURRENT_YEAR:  current_year_q  <= cfg_data_i;
          CFG_EARLIEST_YEAR: earliest_year_q <= cfg_data_i;
          default:           ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (pending_outcomes.size() == 0) begin
          failures_o++;
          if (failures_o <= REPORT_LIMIT)
            $display("%0t: result with no request pending: status %0d/%0d diff %0d",
                     $time, status_a_i, status_b_i, day_difference_i);
        end else begin
          want = pending_outcomes.pop_front();
          if (status_a_i !== want.status_a || status_b_i !== want.status_b ||
              day_difference_i !== want.difference || is_less_i !== want.less ||
              is_equal_i !== want.equal || is_greater_i !== want.greater) begin
            failures_o++;
            if (failures_o <= REPORT_LIMIT)
              $display({"%0t: mismatch: expected status %0d/%0d diff %0d lt/eq/gt %b%b%b,",
                        " got status %0d/%0d diff %0d lt/eq/gt %b%b%b"},
                       $time, want.status_a, want.status_b, want.difference,
                       want.less, want.equal, want.greater,
                       status_a_i, status_b_i, day_difference_i,
                       is_less_i, is_equal_i, is_greater_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        pending_outcomes.push_back(predict_date_pair(year_a_i, month_a_i, day_a_i,
                                                     year_b_i, month_b_i, day_b_i));

      outstanding_o = pending_outcomes.size();
    end
  end

endmodule

@@ dv/date_validate_and_difference_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_validate_and_difference_test
// Drives date pair requests and year register writes into the date check
// block under several idle and stall patterns and gives the verdict.
// ----------------------------------------------------------------------------
// The run opens with a directed list of date pairs: leap days in ordinary,
// century and 400-year years, the year, month and day checks at their limits
// and in priority order, year zero, and pairs far enough apart that the
// difference saturates. It then walks through several year register settings,
// the extremes among them, sending random date pairs that are mostly plausible
// under the current setting and partly raw noise. A final burst is sent while
// the receiver holds off for a long stretch so that the block fills up and
// stalls its request side. All checking happens in the checker instance.
// ----------------------------------------------------------------------------
module date_validate_and_difference_test;
  import dvd_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 190;
  localparam int PRESSURE_ITEMS = 40;
  localparam int HOLD_CYCLES    = 400;
  // Longest quiet stretch in a correct run is the long hold-off above; the
  // random gaps and stalls are far shorter.
  localparam int STUCK_LIMIT    = 2000;

  // Register settings for the random phases: widest window, only the lowest years
  // valid, only the top years valid, 1582 to 2024, nothing valid, an ordinary window.
  localparam int PHASE_CURRENT [PHASES] = '{9999, 1, 9999, 2024, 1, 5000};
  localparam int PHASE_EARLIEST[PHASES] = '{1, 1, 9999, 1582, 9999, 4000};

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_valid = 1'b0;
  cfg_reg_e                 cfg_index = CFG_CURRENT_YEAR;
  logic [YEAR_W-1:0]        cfg_data  = '0;
  logic                     cfg_ready;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [YEAR_W-1:0]        year_a    = '0;
  logic [MONTH_W-1:0]       month_a   = '0;
  logic [DAY_W-1:0]         day_a     = '0;
  logic [YEAR_W-1:0]        year_b    = '0;
  logic [MONTH_W-1:0]       month_b   = '0;
  logic [DAY_W-1:0]         day_b     = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status_a;
  logic [1:0]               status_b;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     is_less;
  logic                     is_equal;
  logic                     is_greater;

  int failures;
  int outstanding;

  // Idle and stall rates in percent, set by the main sequence per phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // The main sequence bumps hold_requests to ask for one long hold-off; the
  // stall process keeps its own count of the ones it has served.
  int hold_requests = 0;
  int holds_served  = 0;

  // Mirror of what was last written, used only to aim the random years.
  int cur_year_cfg      = CUR_YEAR_RST;
  int earliest_year_cfg = EARLIEST_YEAR_RST;

  int stuck_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  date_validate_and_difference dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .year_a_i         (year_a),
    .month_a_i        (month_a),
    .day_a_i          (day_a),
    .year_b_i         (year_b),
    .month_b_i        (month_b),
    .day_b_i          (day_b),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_a_o       (status_a),
    .status_b_o       (status_b),
    .day_difference_o (day_difference),
    .is_less_o        (is_less),
    .is_equal_o       (is_equal),
    .is_greater_o     (is_greater)
  );

  date_pair_checker date_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .year_a_i         (year_a),
    .month_a_i        (month_a),
    .day_a_i          (day_a),
    .year_b_i         (year_b),
    .month_b_i        (month_b),
    .day_b_i          (day_b),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_a_i       (status_a),
    .status_b_i       (status_b),
    .day_difference_i (day_difference),
    .is_less_i        (is_less),
    .is_equal_i       (is_equal),
    .is_greater_i     (is_greater),
    .failures_o       (failures),
    .outstanding_o    (outstanding)
  );

  // Result side back-pressure. Outside a long hold-off the stall is redrawn
  // every cycle from the current rate, so a rate of zero gives an open sink.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any accepted request, result or register write resets it.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. Idle cycles
  // come before the request, never between raising valid and acceptance, so
  // valid stays high across back-to-back requests.
  task automatic send_pair(input int ya, input int ma, input int da,
                           input int yb, input int mb, input int db);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    year_a   <= YEAR_W'(ya);
    month_a  <= MONTH_W'(ma);
    day_a    <= DAY_W'(da);
    year_b   <= YEAR_W'(yb);
    month_b  <= MONTH_W'(mb);
    day_b    <= DAY_W'(db);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A date aimed at the configured window, with its edges and just outside
  // them hit often, and now and then raw noise over the full field widths.
  task automatic pick_date(output int y, output int m, output int d);
    if ($urandom_range(99) < 12) begin
      y = $urandom_range((1 << YEAR_W) - 1);
      m = $urandom_range((1 << MONTH_W) - 1);
      d = $urandom_range((1 << DAY_W) - 1);
    end else begin
      case ($urandom_range(9))
        0:       y = earliest_year_cfg - 1;
        1:       y = earliest_year_cfg;
        2:       y = cur_year_cfg + 1;
        3:       y = cur_year_cfg + 2;
        default: y = $urandom_range(earliest_year_cfg, cur_year_cfg + 1);
      endcase
      m = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(1, 12);
      // Days 29 to 31 are drawn often so month ends and leap days show up.
      d = ($urandom_range(4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    end
  endtask

  // The second date is often the same or in the same month as the first,
  // so the equal flag and small differences get real coverage.
  task automatic send_random_pair();
    int ya, ma, da, yb, mb, db;
    int pick;
    pick_date(ya, ma, da);
    pick = $urandom_range(99);
    if (pick < 15) begin
      yb = ya;
      mb = ma;
      db = da;
    end else if (pick < 35) begin
      yb = ya;
      mb = ma;
      db = $urandom_range(31);
    end else begin
      pick_date(yb, mb, db);
    end
    send_pair(ya, ma, da, yb, mb, db);
  endtask

  // Drops valid and waits until every accepted request has its result. The
  // count is read at the falling edge, after the checker has logged the last
  // acceptance, and the task returns on a rising edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes both year registers back to back; only call while idle.
  task automatic program_years(input int cur, input int earliest);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CURRENT_YEAR;
    cfg_data  <= YEAR_W'(cur);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_EARLIEST_YEAR;
    cfg_data  <= YEAR_W'(earliest);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid         <= 1'b0;
    cur_year_cfg      = cur;
    earliest_year_cfg = earliest;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset window of 1500 to 2025.
    send_pair(2024, 2, 29, 2024, 2, 29);      // leap day, identical dates
    send_pair(2000, 2, 29, 1900, 2, 29);      // 400-year leap vs plain century
    send_pair(2023, 2, 29, 2023, 2, 28);      // leap day in a common year
    send_pair(2000, 4, 31, 2000, 4, 30);      // no extra day outside February
    send_pair(1500, 1, 1, 2025, 12, 31);      // both ends of the year window
    send_pair(1499, 12, 31, 2026, 1, 1);      // just outside the window
    send_pair(1499, 13, 0, 2026, 0, 0);       // bad year outranks month and day
    send_pair(2010, 0, 15, 2010, 13, 15);     // month zero and thirteen
    send_pair(2010, 15, 31, 2010, 12, 0);     // top month code, day zero
    send_pair(2010, 1, 31, 2010, 12, 31);
    send_pair(2000, 3, 1, 2000, 2, 28);       // across a leap day
    send_pair(0, 0, 0, 0, 1, 1);              // year zero rolls back to year -1
    send_pair(16383, 15, 31, 0, 0, 0);        // difference saturates high
    send_pair(0, 0, 0, 16383, 15, 31);        // and low
    send_pair(9999, 12, 31, 1, 1, 1);         // widest unsaturated difference
    send_pair(8191, 7, 16, 4096, 8, 15);
    send_pair(2024, 12, 31, 2025, 1, 1);      // across a year boundary
    settle();

    // The widest window puts the far years and century leap rules in range.
    program_years(9999, 1);
    send_pair(9999, 12, 31, 1, 1, 1);
    send_pair(2100, 2, 29, 2400, 2, 29);
    send_pair(10000, 2, 29, 10001, 1, 1);     // one past current year, then two
    send_pair(1, 1, 1, 0, 12, 31);
    send_pair(4, 2, 29, 100, 2, 29);

    // Random phases. Idle patterns rotate: none, sender idle, receiver
    // stalling, then both sides at once.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_years(PHASE_CURRENT[p], PHASE_EARLIEST[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct     = 24;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_pair();
    end
    settle();

    // Back-pressure burst: the receiver holds off while requests keep
    // coming back to back, so both pipeline registers fill and the request
    // side has to stall until the hold-off ends.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    repeat (PRESSURE_ITEMS) send_random_pair();
    settle();

    // Keep the clock running so any stray result after the last one is caught.
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dvd_pkg.sv
rtl/dvd_date_unit.sv
rtl/dvd_compare.sv
rtl/date_validate_and_difference.sv
dv/date_pair_checker.sv
dv/date_validate_and_difference_test.sv
